// ===== src/fbt_pkg.sv =====
// Shared types and constants for the free block table.
package fbt_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int SLOT_W = 6;
   localparam int COUNT_W = 7;

   localparam int REQ_FIELDS_W = OP_W + SIZE_W + ADDR_W + SIZE_W + SLOT_W;
   localparam int REQ_DATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + SLOT_W + ADDR_W + SIZE_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_FIRST_FIT = 3'd0;
   localparam logic [OP_W-1:0] OP_BEST_FIT = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_ADDR = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== src/fbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fbt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/free_block_table.sv =====
// Free block table: a packed list of (address, size) blocks kept in one RAM and walked by
// a small sequencer with one shared compare unit. The block takes one request beat at a
// time and returns one response beat for it. The table RAM has a single read port, so
// every walk reads one entry per cycle: a fit search or address lookup walks every entry
// unless a first-fit or address hit ends the walk early, an ordered insert searches up to
// the insert point and then moves the later entries up, a remove moves the entries after
// the slot down, and an append, an out-of-range remove, a full-table insert or an unused
// opcode walks nothing. The last step also waits while the previous response beat is
// still held. No clearing pass runs after reset; the block is ready as soon as reset ends.
module free_block_table
   import fbt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode, request_size, block_address, block_size, slot_index, zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, found_slot, found_address, found_size, entry_count, zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_MOVE = 3'd2;
   localparam logic [2:0] S_PUT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [SIZE_W-1:0]     req_size_ff, req_size_in;
   logic [ADDR_W-1:0]     blk_addr_ff, blk_addr_in;
   logic [SIZE_W-1:0]     blk_size_ff, blk_size_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  dir_up_ff, dir_up_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0]     hit_addr_ff, hit_addr_in;
   logic [SIZE_W-1:0]     hit_size_ff, hit_size_in;
   logic                  best_ff, best_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [ADDR_W-1:0]     best_addr_ff, best_addr_in;
   logic [SIZE_W-1:0]     best_size_ff, best_size_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             rd_entry;
   entry_type             new_entry;

   logic [OP_W-1:0]       in_op;
   logic [SIZE_W-1:0]     in_req_size;
   logic [ADDR_W-1:0]     in_blk_addr;
   logic [SIZE_W-1:0]     in_blk_size;
   logic [SLOT_W-1:0]     in_slot;

   logic                  req_fire;
   logic                  issue;
   logic                  use_addr;
   logic [31:0]           cmp_key;
   logic [31:0]           cmp_val;
   logic                  cmp_eq;
   logic                  cmp_gt;
   logic                  cmp_smaller;
   logic [IDX_W-1:0]      ins_pos;

   assign in_op = req_tdata[OP_W-1:0];
   assign in_req_size = req_tdata[OP_W +: SIZE_W];
   assign in_blk_addr = req_tdata[OP_W + SIZE_W +: ADDR_W];
   assign in_blk_size = req_tdata[OP_W + SIZE_W + ADDR_W +: SIZE_W];
   assign in_slot = req_tdata[OP_W + 2 * SIZE_W + ADDR_W +: SLOT_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   fbt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(rd_idx_ff),
      .rdata(ram_rdata)
   );

   assign rd_entry = ram_rdata;
   assign new_entry = '{addr: blk_addr_ff, size: blk_size_ff};

   // Shared compare unit: key from the request against the entry just read.
   assign use_addr = (op_ff == OP_FIND_ADDR) || (op_ff == OP_INSERT);
   assign cmp_key = use_addr ? blk_addr_ff : req_size_ff;
   assign cmp_val = use_addr ? rd_entry.addr : rd_entry.size;
   assign cmp_eq = (cmp_val == cmp_key);
   assign cmp_gt = (cmp_val > cmp_key);
   assign cmp_smaller = (rd_entry.size < best_size_ff);

   assign issue = ((state_ff == S_SCAN) || (state_ff == S_MOVE)) && (left_ff != '0) &&
                  !((state_ff == S_SCAN) && (op_ff != OP_BEST_FIT) && hit_ff);
   assign ins_pos = hit_ff ? hit_idx_ff : IDX_W'(cnt_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rd_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      op_in = op_ff;
      req_size_in = req_size_ff;
      blk_addr_in = blk_addr_ff;
      blk_size_in = blk_size_ff;
      left_in = left_ff;
      rd_idx_in = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pos_in = pos_ff;
      dir_up_in = dir_up_ff;
      status_in = status_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_addr_in = hit_addr_ff;
      hit_size_in = hit_size_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      best_addr_in = best_addr_ff;
      best_size_in = best_size_ff;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = new_entry;

      if (issue) begin
         rd_pend_in = 1'b1;
         cmp_idx_in = rd_idx_ff;
         left_in = left_ff - 1'b1;
         rd_idx_in = ((state_ff == S_MOVE) && dir_up_ff) ? rd_idx_ff - 1'b1 :
                                                           rd_idx_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = in_op;
               req_size_in = in_req_size;
               blk_addr_in = in_blk_addr;
               blk_size_in = in_blk_size;
               status_in = ST_OK;
               hit_in = 1'b0;
               hit_idx_in = '0;
               hit_addr_in = '0;
               hit_size_in = '0;
               best_in = 1'b0;
               dir_up_in = 1'b0;
               left_in = cnt_ff;
               rd_idx_in = '0;
               state_in = S_DONE;
               unique case (in_op) inside
                  OP_FIRST_FIT, OP_BEST_FIT, OP_FIND_ADDR: begin
                     state_in = S_SCAN;
                  end
                  OP_INSERT: begin
                     if (cnt_ff == FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_APPEND: begin
                     if (cnt_ff == FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in = IDX_W'(cnt_ff);
                        state_in = S_PUT;
                     end
                  end
                  OP_REMOVE: begin
                     if (32'(in_slot) >= 32'(cnt_ff)) begin
                        status_in = ST_RANGE;
                     end else begin
                        pos_in = IDX_W'(in_slot);
                        rd_idx_in = IDX_W'(in_slot);
                        left_in = cnt_ff - CNT_W'(in_slot);
                        state_in = S_MOVE;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_pend_ff) begin
               if (op_ff == OP_BEST_FIT) begin
                  if (cmp_eq && !hit_ff) begin
                     hit_in = 1'b1;
                     hit_idx_in = cmp_idx_ff;
                     hit_addr_in = rd_entry.addr;
                     hit_size_in = rd_entry.size;
                  end
                  if (cmp_gt && (!best_ff || cmp_smaller)) begin
                     best_in = 1'b1;
                     best_idx_in = cmp_idx_ff;
                     best_addr_in = rd_entry.addr;
                     best_size_in = rd_entry.size;
                  end
               end else if (!hit_ff &&
                            ((op_ff == OP_FIND_ADDR) ? cmp_eq : (cmp_eq || cmp_gt))) begin
                  hit_in = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  hit_addr_in = rd_entry.addr;
                  hit_size_in = rd_entry.size;
               end
            end else if (!issue) begin
               if (op_ff == OP_INSERT) begin
                  pos_in = ins_pos;
                  left_in = cnt_ff - CNT_W'(ins_pos);
                  rd_idx_in = IDX_W'(cnt_ff - 1'b1);
                  dir_up_in = 1'b1;
                  state_in = S_MOVE;
               end else begin
                  state_in = S_DONE;
                  if (hit_ff) begin
                     status_in = ST_OK;
                  end else if ((op_ff == OP_BEST_FIT) && best_ff) begin
                     status_in = ST_OK;
                     hit_idx_in = best_idx_ff;
                     hit_addr_in = best_addr_ff;
                     hit_size_in = best_size_ff;
                  end else begin
                     status_in = ST_MISS;
                  end
               end
            end
         end
         S_MOVE: begin
            if (rd_pend_ff) begin
               ram_wdata = rd_entry;
               if (dir_up_ff) begin
                  ram_we = 1'b1;
                  ram_waddr = cmp_idx_ff + 1'b1;
               end else if (cmp_idx_ff == pos_ff) begin
                  hit_idx_in = pos_ff;
                  hit_addr_in = rd_entry.addr;
                  hit_size_in = rd_entry.size;
               end else begin
                  ram_we = 1'b1;
                  ram_waddr = cmp_idx_ff - 1'b1;
               end
            end else if (!issue) begin
               if (dir_up_ff) begin
                  state_in = S_PUT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  status_in = ST_OK;
                  state_in = S_DONE;
               end
            end
         end
         S_PUT: begin
            ram_we = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = new_entry;
            cnt_in = cnt_ff + 1'b1;
            status_in = ST_OK;
            hit_idx_in = pos_ff;
            hit_addr_in = blk_addr_ff;
            hit_size_in = blk_size_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = RSP_DATA_W'({COUNT_W'(cnt_ff), hit_size_ff, hit_addr_ff,
                                          SLOT_W'(hit_idx_ff), status_ff});
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff <= op_in;
      req_size_ff <= req_size_in;
      blk_addr_ff <= blk_addr_in;
      blk_size_ff <= blk_size_in;
      left_ff <= left_in;
      rd_idx_ff <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff <= pos_in;
      dir_up_ff <= dir_up_in;
      status_ff <= status_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_addr_ff <= hit_addr_in;
      hit_size_ff <= hit_size_in;
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      best_addr_ff <= best_addr_in;
      best_size_ff <= best_size_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("Entry count exceeds the table depth.");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_MOVE || state_ff == S_PUT))
      else $error("Table write outside a move or put step.");

   a_read_walk: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_SCAN || state_ff == S_MOVE))
      else $error("Pending table read outside a walk.");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(cnt_ff) |-> ($past(state_ff) == S_PUT || $past(state_ff) == S_MOVE))
      else $error("Entry count changed outside a put or remove.");

   a_beat_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("Response beat raised without finishing an operation.");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for free_block_table: directed and random table operations.
module testbench;
   import fbt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [SIZE_W-1:0] bsize;
      logic [ADDR_W-1:0] baddr;
      logic [SIZE_W-1:0] rsize;
      logic [OP_W-1:0]   op;
   } block_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SIZE_W-1:0]   size;
      logic [ADDR_W-1:0]   addr;
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } block_rsp_type;

   typedef enum {GROW_PHASE, MIXED_PHASE, SHRINK_PHASE} load_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [ADDR_W-1:0] table_addr [TABLE_DEPTH];
   logic [SIZE_W-1:0] table_size [TABLE_DEPTH];
   int                table_count = 0;

   block_req_type pending_requests [$];
   block_rsp_type awaited_results [$];

   int requests_queued = 0;
   int requests_accepted = 0;
   int random_made = 0;
   int results_checked = 0;
   int error_count = 0;
   int peak_count = 0;
   int cycle_count = 0;
   int status_seen [4] = '{default: 0};

   logic steady;
   assign steady = requests_accepted >= 700 && requests_accepted < 1000;

   free_block_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic block_rsp_type table_apply(block_req_type r);
      block_rsp_type res;
      int hit;
      int i;
      bit have;
      res = '0;
      hit = 0;
      have = 1'b0;
      case (r.op) inside
         OP_FIRST_FIT: begin
            for (i = 0; i < table_count && !have; i++) begin
               if (table_size[i] >= r.rsize) begin
                  hit = i;
                  have = 1'b1;
               end
            end
            res.status = have ? ST_OK : ST_MISS;
         end
         OP_BEST_FIT: begin
            for (i = 0; i < table_count && !have; i++) begin
               if (table_size[i] == r.rsize) begin
                  hit = i;
                  have = 1'b1;
               end
            end
            if (!have) begin
               for (i = 0; i < table_count; i++) begin
                  if (table_size[i] > r.rsize && (!have || table_size[i] < table_size[hit])) begin
                     hit = i;
                     have = 1'b1;
                  end
               end
            end
            res.status = have ? ST_OK : ST_MISS;
         end
         OP_FIND_ADDR: begin
            for (i = 0; i < table_count && !have; i++) begin
               if (table_addr[i] == r.baddr) begin
                  hit = i;
                  have = 1'b1;
               end
            end
            res.status = have ? ST_OK : ST_MISS;
         end
         OP_INSERT, OP_APPEND: begin
            if (table_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               hit = table_count;
               if (r.op == OP_INSERT) begin
                  for (i = 0; i < table_count; i++) begin
                     if (table_addr[i] >= r.baddr) begin
                        hit = i;
                        break;
                     end
                  end
               end
               for (i = table_count; i > hit; i--) begin
                  table_addr[i] = table_addr[i - 1];
                  table_size[i] = table_size[i - 1];
               end
               table_addr[hit] = r.baddr;
               table_size[hit] = r.bsize;
               table_count++;
               have = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (r.slot >= table_count) begin
               res.status = ST_RANGE;
            end else begin
               res.slot = r.slot;
               res.addr = table_addr[r.slot];
               res.size = table_size[r.slot];
               for (i = r.slot; i + 1 < table_count; i++) begin
                  table_addr[i] = table_addr[i + 1];
                  table_size[i] = table_size[i + 1];
               end
               table_count--;
            end
         end
         default: ;
      endcase
      if (have) begin
         res.slot = hit[SLOT_W-1:0];
         res.addr = table_addr[hit];
         res.size = table_size[hit];
      end
      res.count = COUNT_W'(table_count);
      return res;
   endfunction

   // Values lean toward the extremes, small numbers that collide, and neighbors of
   // what the table already holds, so that exact hits, ties and near misses are common.
   function automatic logic [31:0] draw_word(bit from_sizes);
      int k;
      int pick;
      logic [31:0] base;
      k = $urandom_range(0, 15);
      if (k == 0)
         return '0;
      if (k == 1)
         return '1;
      if (k < 6)
         return $urandom_range(0, 31);
      if (k < 11 && table_count > 0) begin
         pick = $urandom_range(0, table_count - 1);
         base = from_sizes ? table_size[pick] : table_addr[pick];
         return base + $urandom_range(0, 2) - 1;
      end
      return $urandom;
   endfunction

   function automatic block_req_type draw_request(load_phase_type phase);
      block_req_type item;
      int roll;
      item.op = OP_FIRST_FIT;
      item.rsize = $urandom;
      item.baddr = $urandom;
      item.bsize = $urandom;
      item.slot = SLOT_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         item.op = (roll == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
         return item;
      end
      case (phase)
         GROW_PHASE: begin
            item.op = roll < 45 ? OP_INSERT : roll < 70 ? OP_APPEND : roll < 78 ? OP_FIRST_FIT :
                      roll < 86 ? OP_BEST_FIT : roll < 93 ? OP_FIND_ADDR : OP_REMOVE;
         end
         SHRINK_PHASE: begin
            item.op = roll < 62 ? OP_REMOVE : roll < 70 ? OP_INSERT : roll < 75 ? OP_APPEND :
                      roll < 84 ? OP_FIRST_FIT : roll < 92 ? OP_BEST_FIT : OP_FIND_ADDR;
         end
         default: begin
            item.op = roll < 19 ? OP_FIRST_FIT : roll < 36 ? OP_BEST_FIT : roll < 52 ? OP_FIND_ADDR :
                      roll < 68 ? OP_INSERT : roll < 84 ? OP_APPEND : OP_REMOVE;
         end
      endcase
      case (item.op) inside
         OP_FIRST_FIT, OP_BEST_FIT: item.rsize = draw_word(1'b1);
         OP_FIND_ADDR: item.baddr = draw_word(1'b0);
         OP_INSERT, OP_APPEND: begin
            item.baddr = draw_word(1'b0);
            item.bsize = draw_word(1'b1);
         end
         OP_REMOVE: begin
            if (table_count > 0 && $urandom_range(0, 9) != 0)
               item.slot = SLOT_W'($urandom_range(0, table_count - 1));
         end
         default: ;
      endcase
      return item;
   endfunction

   task automatic push_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] rsize,
                               input logic [ADDR_W-1:0] baddr, input logic [SIZE_W-1:0] bsize,
                               input logic [SLOT_W-1:0] slot);
      block_req_type item;
      item.op = op;
      item.rsize = rsize;
      item.baddr = baddr;
      item.bsize = bsize;
      item.slot = slot;
      pending_requests.insert(pending_requests.size(), item);
      requests_queued++;
   endtask

   task automatic wait_drained();
      while (results_checked != requests_queued)
         @(posedge clock);
   endtask

   task automatic report_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      logic valid_next;
      block_req_type next_req;
      valid_next = req_tvalid;
      next_req = block_req_type'(req_tdata[REQ_FIELDS_W-1:0]);
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.insert(awaited_results.size(), table_apply(next_req));
            requests_accepted++;
            valid_next = 1'b0;
         end
         if (!valid_next && pending_requests.size() > 0 &&
             (steady || $urandom_range(0, 99) >= 25)) begin
            next_req = pending_requests.pop_front();
            valid_next = 1'b1;
         end
      end
      req_tvalid <= valid_next;
      req_tdata <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, next_req};
   end

   always @(posedge clock) begin
      block_rsp_type got;
      block_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = block_rsp_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (awaited_results.size() == 0) begin
               error_count++;
               $display("%0t: response beat with no request waiting, expected none, actual %h",
                        $time, got);
            end else begin
               want = awaited_results.pop_front();
               report_field("status", 32'(want.status), 32'(got.status));
               report_field("found_slot", 32'(want.slot), 32'(got.slot));
               report_field("found_address", want.addr, got.addr);
               report_field("found_size", want.size, got.size);
               report_field("entry_count", 32'(want.count), 32'(got.count));
               results_checked++;
               status_seen[got.status]++;
               if (got.count > peak_count)
                  peak_count = got.count;
            end
         end
         rsp_tready <= steady || $urandom_range(0, 99) >= 25;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.", cycle_count,
                  requests_queued - results_checked);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      load_phase_type phase;
      int phase_left;
      block_req_type item;
      // Empty table: every search misses, removal is out of range, spare opcodes do nothing.
      push_request(OP_FIRST_FIT, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_BEST_FIT, 32'hFFFF_FFFF, 32'h0, 32'h0, 6'd0);
      push_request(OP_FIND_ADDR, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_REMOVE, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_UNUSED_LO, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      // Build a small table with an equal-address insert and an out-of-order append.
      push_request(OP_APPEND, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
      push_request(OP_INSERT, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_INSERT, 32'h0, 32'h8000_0000, 32'd100, 6'd0);
      push_request(OP_INSERT, 32'h0, 32'h8000_0000, 32'd50, 6'd0);
      push_request(OP_APPEND, 32'h0, 32'h10, 32'd100, 6'd0);
      push_request(OP_FIRST_FIT, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_FIRST_FIT, 32'hFFFF_FFFF, 32'h0, 32'h0, 6'd0);
      push_request(OP_FIRST_FIT, 32'd60, 32'h0, 32'h0, 6'd0);
      push_request(OP_BEST_FIT, 32'd100, 32'h0, 32'h0, 6'd0);
      push_request(OP_BEST_FIT, 32'd60, 32'h0, 32'h0, 6'd0);
      push_request(OP_BEST_FIT, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_FIND_ADDR, 32'h0, 32'h8000_0000, 32'h0, 6'd0);
      push_request(OP_FIND_ADDR, 32'h0, 32'h1234_5678, 32'h0, 6'd0);
      push_request(OP_UNUSED_HI, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_REMOVE, 32'h0, 32'h0, 32'h0, 6'd63);
      push_request(OP_REMOVE, 32'h0, 32'h0, 32'h0, 6'd4);
      push_request(OP_REMOVE, 32'h0, 32'h0, 32'h0, 6'd0);
      push_request(OP_FIRST_FIT, 32'hFFFF_FFFF, 32'h0, 32'h0, 6'd0);
      push_request(OP_BEST_FIT, 32'd101, 32'h0, 32'h0, 6'd0);

      // The random part cycles the table from empty to full and back, so that full-table
      // inserts and removals from a nearly empty table both come up repeatedly.
      phase = GROW_PHASE;
      phase_left = 0;
      while (random_made < RANDOM_ITEMS) begin
         while (pending_requests.size() > 1)
            @(posedge clock);
         item = draw_request(phase);
         pending_requests.insert(pending_requests.size(), item);
         requests_queued++;
         if (item.op <= OP_REMOVE) begin
            random_made++;
            if (random_made % 400 == 0)
               wait_drained();
         end
         case (phase)
            GROW_PHASE: begin
               if (table_count == TABLE_DEPTH)
                  phase_left++;
               if (phase_left >= 8) begin
                  phase = MIXED_PHASE;
                  phase_left = 0;
               end
            end
            MIXED_PHASE: begin
               phase_left++;
               if (phase_left >= 150) begin
                  phase = SHRINK_PHASE;
                  phase_left = 0;
               end
            end
            default: begin
               if (table_count == 0)
                  phase_left++;
               if (phase_left >= 4) begin
                  phase = GROW_PHASE;
                  phase_left = 0;
               end
            end
         endcase
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d random), checked %0d responses, peak occupancy %0d of %0d.",
               requests_queued, random_made, results_checked, peak_count, TABLE_DEPTH);
      $display("Statuses seen: %0d ok, %0d not found, %0d full, %0d out of range; %0d errors.",
               status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_FULL],
               status_seen[ST_RANGE], error_count);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (awaited_results.size() != 0)
            $display("%0d expected responses never arrived.", awaited_results.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
